>>> hdl/weighted_score_argmax_select_unit_defines.svh
// Assertion helpers used by the checker.
`ifndef WEIGHTED_SCORE_ARGMAX_SELECT_UNIT_DEFINES_SVH
`define WEIGHTED_SCORE_ARGMAX_SELECT_UNIT_DEFINES_SVH

// Clocked on clock, quiet while reset is high.
`define WSA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`define WSA_ASSERT(lbl, prop) `WSA_CHECK(lbl, prop, "weighted score selector check failed")

`endif

>>> hdl/wsa_pkg.sv
`default_nettype none
package wsa_pkg;

   localparam int unsigned MAX_CANDIDATES = 256;
   localparam int unsigned POS_W          = $clog2(MAX_CANDIDATES + 1);

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned ADD_W   = DATA_W + 2;
   localparam int unsigned SCORE_W = 34;
   localparam int unsigned INDEX_W = 8;
   // quotient of 2^24/(cost+256) is at most 65536: 17 bits
   localparam int unsigned QUOT_W  = DATA_W + 1;
   localparam int unsigned STEP_W  = $clog2(QUOT_W);

   localparam logic [QUOT_W-1:0] DIV_BIAS = QUOT_W'(256);
   // dividend 2^24 shifted down past the 17 quotient positions
   localparam logic [QUOT_W-1:0] REM_INIT = QUOT_W'(128);

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_COST_WT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERF_WT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUST_WT = 2'd2;

   localparam logic [DATA_W-1:0] COST_WT_RESET  = 16'd19661;
   localparam logic [DATA_W-1:0] PERF_WT_RESET  = 16'd26214;
   localparam logic [DATA_W-1:0] TRUST_WT_RESET = 16'd19661;

   typedef struct packed {
      logic load;
      logic step;
      logic top_bit;
   } wsa_ctl_type;

   typedef struct packed {
      logic [DATA_W-1:0] cost_wt;
      logic [DATA_W-1:0] perf_wt;
      logic [DATA_W-1:0] trust_wt;
   } wsa_weights_type;

endpackage
`default_nettype wire

>>> hdl/weighted_score_argmax_select_unit.sv
`default_nettype none
// Scores one candidate per item as cost_wt*floor(2^24/(cost+256)) (capped at 65535)
// + perf_wt*success + trust_wt*trust, keeps the highest score of the run (ties keep
// the earlier candidate) and emits index, score and overflow status on the item marked last.
// Each item goes through the accept, 17 steps of the serial reciprocal divider (one
// quotient bit per cycle, fed straight into a bit-serial multiply-accumulate that forms all
// three products together) and the compare/update. req_stall is high after an accept through
// its update; on a last item the update also waits for the result register to be free,
// which holds one finished result while the next run starts. Weights may be written only
// while no item is in flight; a write to an index beyond the three registers is ignored.
module weighted_score_argmax_select_unit import wsa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [DATA_W-1:0]    req_cost_estimate,
   input  wire logic [DATA_W-1:0]    req_success_rate,
   input  wire logic [DATA_W-1:0]    req_trust_level,
   input  wire logic                 req_last_candidate,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [INDEX_W-1:0]        rsp_win_index,
   output logic [SCORE_W-1:0]        rsp_best_value,
   output logic                      rsp_status,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CALC   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(QUOT_W - 1);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_ff, last_in;
   wsa_weights_type   weights_ff, weights_in;

   wsa_ctl_type        ctl;
   logic               accept;
   logic               update;
   logic               q_bit;
   logic [SCORE_W-1:0] score;
   logic               out_free;

   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign req_stall   = (state_ff != ST_IDLE);
   assign update      = (state_ff == ST_UPDATE) && (!last_ff || out_free);
   assign ctl.load    = accept;
   assign ctl.step    = (state_ff == ST_CALC);
   assign ctl.top_bit = (step_ff == STEP_TOP);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
               step_in  = STEP_TOP;
               last_in  = req_last_candidate;
            end
         end
         ST_CALC: begin
            if (step_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_UPDATE: begin
            if (update) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      weights_in = weights_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COST_WT:  weights_in.cost_wt  = csr_wdata;
            CSR_PERF_WT:  weights_in.perf_wt  = csr_wdata;
            CSR_TRUST_WT: weights_in.trust_wt = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         weights_ff.cost_wt  <= COST_WT_RESET;
         weights_ff.perf_wt  <= PERF_WT_RESET;
         weights_ff.trust_wt <= TRUST_WT_RESET;
      end else begin
         state_ff   <= state_in;
         weights_ff <= weights_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      last_ff <= last_in;
   end

   wsa_recip u_recip (
      .clock (clock),
      .ctl   (ctl),
      .cost  (req_cost_estimate),
      .q_bit (q_bit)
   );

   wsa_mac u_mac (
      .clock   (clock),
      .ctl     (ctl),
      .weights (weights_ff),
      .q_bit   (q_bit),
      .success (req_success_rate),
      .trust   (req_trust_level),
      .score   (score)
   );

   wsa_argmax u_argmax (
      .clock          (clock),
      .reset          (reset),
      .update         (update),
      .last           (last_ff),
      .score          (score),
      .rsp_stall      (rsp_stall),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_win_index  (rsp_win_index),
      .rsp_best_value (rsp_best_value),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

>>> hdl/wsa_recip.sv
`default_nettype none
// Restoring divider, one quotient bit per step, MSB first.
module wsa_recip import wsa_pkg::*; (
   input  wire logic              clock,
   input  wire wsa_ctl_type       ctl,
   input  wire logic [DATA_W-1:0] cost,
   output logic                   q_bit
);

   logic [QUOT_W-1:0] divisor_ff, divisor_in;
   logic [QUOT_W-1:0] rem_ff, rem_in;
   logic              sat_ff, sat_in;
   logic [QUOT_W:0]   trial;
   logic [QUOT_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   // zero cost gives exactly 65536: stream 65535 instead
   assign q_bit = sat_ff ? !ctl.top_bit : fits;

   always_comb begin
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      sat_in     = sat_ff;
      if (ctl.load) begin
         divisor_in = {1'b0, cost} + DIV_BIAS;
         rem_in     = REM_INIT;
         sat_in     = (cost == '0);
      end else if (ctl.step) begin
         rem_in = fits ? diff[QUOT_W-1:0] : trial[QUOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      sat_ff     <= sat_in;
   end

endmodule
`default_nettype wire

>>> hdl/wsa_mac.sv
`default_nettype none
// Bit-serial sum of three products, Horner style, multiplier bits MSB first.
module wsa_mac import wsa_pkg::*; (
   input  wire logic               clock,
   input  wire wsa_ctl_type        ctl,
   input  wire wsa_weights_type    weights,
   input  wire logic               q_bit,
   input  wire logic [DATA_W-1:0]  success,
   input  wire logic [DATA_W-1:0]  trust,
   output logic [SCORE_W-1:0]      score
);

   logic [DATA_W-1:0]  succ_sh_ff, succ_sh_in;
   logic [DATA_W-1:0]  trust_sh_ff, trust_sh_in;
   logic [SCORE_W-1:0] acc_ff, acc_in;
   logic               succ_bit, trust_bit;
   logic [ADD_W-1:0]   addend;

   // the 17th (top) quotient bit has no partner in the 16-bit rates
   assign succ_bit  = !ctl.top_bit && succ_sh_ff[DATA_W-1];
   assign trust_bit = !ctl.top_bit && trust_sh_ff[DATA_W-1];

   assign addend = {2'b00, weights.cost_wt  & {DATA_W{q_bit}}}
                 + {2'b00, weights.perf_wt  & {DATA_W{succ_bit}}}
                 + {2'b00, weights.trust_wt & {DATA_W{trust_bit}}};

   always_comb begin
      succ_sh_in  = succ_sh_ff;
      trust_sh_in = trust_sh_ff;
      acc_in      = acc_ff;
      if (ctl.load) begin
         succ_sh_in  = success;
         trust_sh_in = trust;
         acc_in      = '0;
      end else if (ctl.step) begin
         acc_in = {acc_ff[SCORE_W-2:0], 1'b0} + {{(SCORE_W - ADD_W){1'b0}}, addend};
         if (!ctl.top_bit) begin
            succ_sh_in  = {succ_sh_ff[DATA_W-2:0], 1'b0};
            trust_sh_in = {trust_sh_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      succ_sh_ff  <= succ_sh_in;
      trust_sh_ff <= trust_sh_in;
      acc_ff      <= acc_in;
   end

   assign score = acc_ff;

endmodule
`default_nettype wire

>>> hdl/wsa_argmax.sv
`default_nettype none
// Running best of the run, plus the result register.
module wsa_argmax import wsa_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               update,
   input  wire logic               last,
   input  wire logic [SCORE_W-1:0] score,
   input  wire logic               rsp_stall,
   output logic                    out_free,
   output logic                    rsp_valid,
   output logic [INDEX_W-1:0]      rsp_win_index,
   output logic [SCORE_W-1:0]      rsp_best_value,
   output logic                    rsp_status
);

   localparam int unsigned IW = (POS_W > INDEX_W) ? POS_W : INDEX_W;
   localparam logic [POS_W-1:0]   POS_LIMIT = POS_W'(MAX_CANDIDATES);
   localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(MAX_CANDIDATES - 1);
   localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

   logic [SCORE_W-1:0] top_score_ff, top_score_in;
   logic [INDEX_W-1:0] top_index_ff, top_index_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic               have_ff, have_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [SCORE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               at_limit;
   logic [POS_W-1:0]   pos_idx;
   logic [IW-1:0]      idx_wide;
   logic [INDEX_W-1:0] idx;
   logic               take;
   logic [SCORE_W-1:0] win_score;
   logic [INDEX_W-1:0] win_index;

   assign at_limit  = position_ff >= POS_LIMIT;
   assign pos_idx   = at_limit ? POS_LAST : position_ff;
   assign idx_wide  = IW'(pos_idx);
   assign idx       = (idx_wide > IW'(INDEX_MAX)) ? INDEX_MAX : idx_wide[INDEX_W-1:0];
   // ties keep the earlier candidate
   assign take      = !have_ff || (score > top_score_ff);
   assign win_score = take ? score : top_score_ff;
   assign win_index = take ? idx : top_index_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      top_score_in  = top_score_ff;
      top_index_in  = top_index_ff;
      position_in   = position_ff;
      have_in       = have_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (update) begin
         if (last) begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = win_index;
            rsp_value_in  = win_score;
            rsp_status_in = ovf_ff || at_limit;
            position_in   = '0;
            have_in       = 1'b0;
            ovf_in        = 1'b0;
         end else begin
            top_score_in = win_score;
            top_index_in = win_index;
            have_in      = 1'b1;
            ovf_in       = ovf_ff || at_limit;
            if (!at_limit) begin
               position_in = position_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         have_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         have_ff      <= have_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_score_ff  <= top_score_in;
      top_index_ff  <= top_index_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_win_index  = rsp_index_ff;
   assign rsp_best_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

>>> hdl/wsa_checker.sv
`default_nettype none
`include "weighted_score_argmax_select_unit_defines.svh"
module wsa_checker import wsa_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               req_last_candidate,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [INDEX_W-1:0] rsp_win_index,
   input wire logic [SCORE_W-1:0] rsp_best_value,
   input wire logic               rsp_status
);

   logic                       take_in;
   logic [INDEX_W+SCORE_W:0]   rsp_word;

   assign take_in  = req_valid && !req_stall;
   assign rsp_word = {rsp_win_index, rsp_best_value, rsp_status};

   // one item at a time: busy straight after an accept
   `WSA_ASSERT(a_busy_after_accept, take_in |=> req_stall)

   // the input stays closed through the divider steps into the update
   `WSA_ASSERT(a_busy_span, take_in |-> ##18 req_stall)

   // a result only ever appears out of a busy cycle
   `WSA_ASSERT(a_result_from_work, $rose(rsp_valid) |-> $past(req_stall))

   // an item not marked last produces no result
   `WSA_ASSERT(a_no_result_midrun, take_in && !req_last_candidate |-> ##19 !$rose(rsp_valid))

   `WSA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))

endmodule

bind weighted_score_argmax_select_unit wsa_checker u_checker (.*);
`default_nettype wire

>>> tb/tb_weighted_score_argmax_select_unit.sv
`timescale 1ns / 1ps

module tb_weighted_score_argmax_select_unit;
   import wsa_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 400_000;
   localparam int unsigned SETTLE_CYCLES = 40;
   // index 3 has no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [DATA_W-1:0] cost;
      logic [DATA_W-1:0] succ;
      logic [DATA_W-1:0] trust;
      logic              last;
   } cand_type;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic [SCORE_W-1:0] value;
      logic               status;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DATA_W-1:0]    req_cost_estimate = '0;
   logic [DATA_W-1:0]    req_success_rate = '0;
   logic [DATA_W-1:0]    req_trust_level = '0;
   logic                 req_last_candidate = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [INDEX_W-1:0]   rsp_win_index;
   logic [SCORE_W-1:0]   rsp_best_value;
   logic                 rsp_status;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wdata = '0;

   weighted_score_argmax_select_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cost_estimate  (req_cost_estimate),
      .req_success_rate   (req_success_rate),
      .req_trust_level    (req_trust_level),
      .req_last_candidate (req_last_candidate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_win_index      (rsp_win_index),
      .rsp_best_value     (rsp_best_value),
      .rsp_status         (rsp_status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // weights and run state as the block should hold them
   logic [DATA_W-1:0]  w_cost = COST_WT_RESET;
   logic [DATA_W-1:0]  w_perf = PERF_WT_RESET;
   logic [DATA_W-1:0]  w_trust = TRUST_WT_RESET;
   logic [SCORE_W-1:0] run_top = '0;
   int unsigned        run_top_idx = 0;
   int unsigned        run_pos = 0;
   bit                 run_has_top = 1'b0;
   bit                 run_ovf = 1'b0;

   cand_type    cand_q[$];
   verdict_type verdict_q[$];
   cand_type    on_wire;
   verdict_type want;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned faults = 0;
   int unsigned cands_taken = 0;
   int unsigned verdicts_seen = 0;
   int unsigned ovf_seen = 0;
   int unsigned runs_queued = 0;
   int unsigned cycles = 0;

   function automatic logic [SCORE_W-1:0] weigh(input cand_type c);
      longint unsigned recip;
      longint unsigned sum;
      recip = (64'd1 << 24) / (64'(c.cost) + 64'd256);
      if (recip > 64'd65535) recip = 64'd65535;
      sum = 64'(w_cost) * recip + 64'(w_perf) * 64'(c.succ) + 64'(w_trust) * 64'(c.trust);
      return sum[SCORE_W-1:0];
   endfunction

   task automatic rank_candidate(input cand_type c);
      logic [SCORE_W-1:0] s;
      int unsigned slot;
      verdict_type v;
      s = weigh(c);
      if (run_pos >= MAX_CANDIDATES) begin
         run_ovf = 1'b1;
         slot = MAX_CANDIDATES - 1;
      end else begin
         slot = run_pos;
      end
      if (slot > 255) slot = 255;
      // ties keep the earlier item
      if (!run_has_top || s > run_top) begin
         run_top = s;
         run_top_idx = slot;
         run_has_top = 1'b1;
      end
      if (run_pos < MAX_CANDIDATES) run_pos++;
      if (c.last) begin
         v.index = run_top_idx[INDEX_W-1:0];
         v.value = run_top;
         v.status = run_ovf;
         verdict_q.push_back(v);
         run_top = '0;
         run_top_idx = 0;
         run_pos = 0;
         run_has_top = 1'b0;
         run_ovf = 1'b0;
      end
   endtask

   // driver: valid held until taken, fresh item only when the wire is free
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            rank_candidate(on_wire);
            cands_taken++;
         end
         if (cand_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            on_wire = cand_q.pop_front();
            req_valid <= 1'b1;
            req_cost_estimate <= on_wire.cost;
            req_success_rate <= on_wire.succ;
            req_trust_level <= on_wire.trust;
            req_last_candidate <= on_wire.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
               $error("result with nothing expected: index %0d value %0d status %0d",
                      rsp_win_index, rsp_best_value, rsp_status);
               faults++;
            end else begin
               want = verdict_q.pop_front();
               if (want.status) ovf_seen++;
               if (rsp_win_index !== want.index) begin
                  $error("win_index: expected %0d, got %0d", want.index, rsp_win_index);
                  faults++;
               end
               if (rsp_best_value !== want.value) begin
                  $error("best_value: expected %0d, got %0d", want.value, rsp_best_value);
                  faults++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  faults++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  verdict_q.size());
         $display("** weighted_score_argmax_select_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   task automatic add_cand(input logic [DATA_W-1:0] cost, input logic [DATA_W-1:0] succ,
                           input logic [DATA_W-1:0] trust, input logic last);
      cand_type c;
      c.cost = cost;
      c.succ = succ;
      c.trust = trust;
      c.last = last;
      cand_q.push_back(c);
      if (last) runs_queued++;
   endtask

   task automatic add_run(input int len, input bit last_wins);
      for (int k = 0; k < len; k++) begin
         if (last_wins && k == len - 1)
            add_cand('0, '1, '1, 1'b1);
         else
            add_cand(rand_word(), rand_word(), rand_word(), k == len - 1);
      end
   endtask

   task automatic add_short_runs(input int n_items);
      int left;
      int len;
      left = n_items;
      while (left > 0) begin
         len = $urandom_range(1, 8);
         if (len > left) len = left;
         add_run(len, 1'b0);
         left -= len;
      end
   endtask

   // wait for every queued item and result, then let the pipe go quiet
   task automatic drain();
      while (cand_q.size() != 0 || req_valid || verdict_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_COST_WT:  w_cost = val;
         CSR_PERF_WT:  w_perf = val;
         CSR_TRUST_WT: w_trust = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_weights(input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] p,
                              input logic [DATA_W-1:0] t);
      write_reg(CSR_COST_WT, c);
      write_reg(CSR_PERF_WT, p);
      write_reg(CSR_TRUST_WT, t);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, on reset weights, then after a write to the spare index and on zero weights
      add_cand('0, '1, '1, 1'b1);
      add_cand('1, '0, '0, 1'b1);
      repeat (2) add_cand(16'h0100, 16'h8000, 16'h8000, 1'b0);
      add_cand(16'h0100, 16'h8000, 16'h8000, 1'b1);
      add_cand(16'h0100, 16'h1000, 16'h0000, 1'b0);
      add_cand(16'h0100, 16'h2000, 16'h0000, 1'b0);
      add_cand(16'h0100, 16'h4000, 16'h0000, 1'b0);
      add_cand(16'h0100, 16'h8000, 16'h0000, 1'b1);
      add_cand(16'h4000, 16'h0100, 16'h0100, 1'b0);
      add_cand(16'h0000, 16'hF000, 16'hF000, 1'b0);
      add_cand(16'h0000, 16'hF000, 16'hF000, 1'b1);
      add_cand(16'h0001, 16'h0000, 16'h0000, 1'b1);
      add_cand(16'h8000, 16'h5555, 16'hAAAA, 1'b1);
      drain();
      write_reg(CSR_SPARE, 16'h1234);
      add_cand(16'h00FF, 16'h7FFF, 16'h0001, 1'b0);
      add_cand(16'hFF00, 16'hFFFF, 16'hFFFE, 1'b1);
      drain();
      set_weights('0, '0, '0);
      add_cand(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
      add_cand(16'h1234, 16'h0000, 16'h0000, 1'b1);
      drain();

      // full weights, no idling; one run of exactly the maximum length
      set_weights('1, '1, '1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      add_run(MAX_CANDIDATES, 1'b1);
      add_short_runs(85);
      drain();

      // sparse sender, with a full pause half way
      set_weights('0, '1, '0);
      send_idle_pct = 75;
      rsp_stall_pct = 0;
      add_short_runs(45);
      drain();
      add_short_runs(40);
      drain();

      // slow receiver; one overlong run
      set_weights('1, '0, '0);
      send_idle_pct = 0;
      rsp_stall_pct = 75;
      add_run(MAX_CANDIDATES + 4, 1'b0);
      add_short_runs(85);
      drain();

      set_weights(rand_word(), rand_word(), rand_word());
      send_idle_pct = 24;
      rsp_stall_pct = 24;
      add_short_runs(85);
      drain();

      $display("%0d candidates in %0d runs scored, %0d results compared (%0d overflowed),",
               cands_taken, runs_queued, verdicts_seen, ovf_seen);
      $display("across six weight settings and four idle/stall mixes.");
      if (faults == 0) begin
         $display("** weighted_score_argmax_select_unit: PASSED **");
      end else begin
         $display("** weighted_score_argmax_select_unit: FAILED **");
      end
      $finish;
   end

endmodule
